FILE: rtl/core/tcsf_pkg.sv
// Shared constants for the two-color sine fade pattern generator.
// Holds register indexes, the count bound and the sine weight lookup.
// No dependencies.
package tcsf_pkg;

  localparam int unsigned MaxPixels     = 1024;
  localparam int unsigned SineTableBits = 8;

  // Largest strip length the 10-bit address and slot state can cover.
  localparam logic [10:0] CountBound =
      (MaxPixels < 1024) ? 11'(MaxPixels) : 11'd1024;

  // Steps of the bit-serial remainder pass (11-bit dividend).
  localparam logic [3:0] NormSteps = 4'd11;

  localparam int unsigned PhaseDrop = 16 - SineTableBits;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] RegFirstColor  = 2'd0;
  localparam logic [1:0] RegSecondColor = 2'd1;
  localparam logic [1:0] RegPixelCount  = 2'd2;
  localparam logic [1:0] RegPhaseStep   = 2'd3;

  // round(128 * sin(k * pi / 128)) for k = 0..64, one quarter wave.
  localparam logic [7:0] QuarterSine [65] = '{
    8'd0,   8'd3,   8'd6,   8'd9,   8'd13,  8'd16,  8'd19,  8'd22,
    8'd25,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
    8'd49,  8'd52,  8'd55,  8'd58,  8'd60,  8'd63,  8'd66,  8'd68,
    8'd71,  8'd74,  8'd76,  8'd79,  8'd81,  8'd84,  8'd86,  8'd88,
    8'd91,  8'd93,  8'd95,  8'd97,  8'd99,  8'd101, 8'd103, 8'd105,
    8'd106, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114, 8'd116, 8'd117,
    8'd118, 8'd119, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124, 8'd125,
    8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd128, 8'd128, 8'd128,
    8'd128
  };

  // Weight a in Q0.8 for a 16-bit phase: 128 +/- quarter-wave value, saturated.
  function automatic logic [7:0] sine_weight(input logic [15:0] phase);
    logic [15:0] quant;
    logic [7:0]  idx;
    logic [5:0]  r;
    logic [6:0]  mirror;
    logic [7:0]  s;
    logic [8:0]  a;
    quant  = (phase >> PhaseDrop) << PhaseDrop;
    idx    = quant[15:8];
    r      = idx[5:0];
    mirror = 7'd64 - {1'b0, r};
    s      = idx[6] ? QuarterSine[mirror] : QuarterSine[r];
    a      = idx[7] ? (9'd128 - {1'b0, s}) : (9'd128 + {1'b0, s});
    return (a > 9'd255) ? 8'd255 : a[7:0];
  endfunction

endpackage

FILE: rtl/core/two_color_sine_fade_cycle.sv
// Top level of the two-color sine fade pattern generator.
// Uses tcsf_pkg for register indexes, the count bound and the sine weight.
// Contains the frame state, the blend pipeline and the APB register file.

// The block takes one pixel request per cycle while s_axis_tready is high and
// returns one pixel per request through two registers: the first holds the
// address, frame end flag and sine weight looked up from the frame state, the
// second holds the blended colors and acts as the output register. Input beats
// whose request bit is zero are taken and produce no pixel. Writing
// pixel_count starts a pass that reduces the rotation and the current address
// modulo the new count one bit per cycle; s_axis_tready stays low during that pass.
module two_color_sine_fade_cycle (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] request, [7:1] zero
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [9:0] pixel_address, [17:10] red, [25:18] green, [33:26] blue, [39:34] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,   // frame_last
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [23:0] first_color_q;
  logic [23:0] second_color_q;
  logic [10:0] pixel_count_q;
  logic [15:0] phase_step_q;

  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_color_q  <= '0;
      second_color_q <= '0;
      pixel_count_q  <= 11'd1024;
      phase_step_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tcsf_pkg::RegFirstColor:  first_color_q  <= pwdata[23:0];
        tcsf_pkg::RegSecondColor: second_color_q <= pwdata[23:0];
        tcsf_pkg::RegPixelCount:  pixel_count_q  <= pwdata[10:0];
        tcsf_pkg::RegPhaseStep:   phase_step_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tcsf_pkg::RegFirstColor:  prdata = {8'd0, first_color_q};
      tcsf_pkg::RegSecondColor: prdata = {8'd0, second_color_q};
      tcsf_pkg::RegPixelCount:  prdata = {21'd0, pixel_count_q};
      tcsf_pkg::RegPhaseStep:   prdata = {16'd0, phase_step_q};
      default:                  prdata = '0;
    endcase
  end

  // Effective strip length: zero counts as one, large values clamp to the bound.
  logic [10:0] count_eff;
  always_comb begin
    if (pixel_count_q == 11'd0) begin
      count_eff = 11'd1;
    end else if (pixel_count_q > tcsf_pkg::CountBound) begin
      count_eff = tcsf_pkg::CountBound;
    end else begin
      count_eff = pixel_count_q;
    end
  end

  // Frame state. rot_q is the raw rotation; rot_mod_q and addr_q are kept
  // reduced modulo the effective count so the per-pixel update is one compare.
  logic [9:0]  slot_q, slot_d;
  logic [15:0] phase_q, phase_d;
  logic [9:0]  rot_q, rot_d;
  logic [9:0]  rot_mod_q, rot_mod_d;
  logic [9:0]  addr_q, addr_d;

  // Remainder pass after a pixel_count write.
  logic [3:0]  nrm_cnt_q, nrm_cnt_d;
  logic [10:0] rem_rot_q, rem_rot_d;
  logic [10:0] rem_adr_q, rem_adr_d;
  logic        nrm_busy;
  logic        start_nrm;

  // Pipeline.
  logic        s1_valid_q;
  logic [9:0]  s1_addr_q;
  logic        s1_last_q;
  logic [7:0]  s1_weight_q;
  logic        out_valid_q;
  logic [9:0]  out_addr_q;
  logic [7:0]  out_red_q, out_green_q, out_blue_q;
  logic        out_last_q;

  logic        out_take;
  logic        s1_adv;
  logic        in_beat;
  logic        pix_req;

  assign nrm_busy  = (nrm_cnt_q != 4'd0);
  assign start_nrm = cfg_wr && (cfg_idx == tcsf_pkg::RegPixelCount);

  assign out_take      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_take;
  assign s_axis_tready = !nrm_busy && (!s1_valid_q || out_take);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign pix_req       = in_beat && s_axis_tdata[0];

  // Per-pixel state step.
  logic        is_last;
  logic [10:0] slot_inc;
  logic [10:0] addr_inc;
  logic [10:0] rot_inc;
  logic [9:0]  addr_wrap;
  logic [9:0]  rot_wrap;

  assign slot_inc  = {1'b0, slot_q} + 11'd1;
  assign addr_inc  = {1'b0, addr_q} + 11'd1;
  assign rot_inc   = {1'b0, rot_mod_q} + 11'd1;
  assign is_last   = (slot_inc >= count_eff);
  assign addr_wrap = (addr_inc >= count_eff) ? 10'd0 : addr_inc[9:0];
  assign rot_wrap  = (rot_inc >= count_eff) ? 10'd0 : rot_inc[9:0];

  // One restoring remainder step per cycle for both dividends.
  logic [10:0] sum_raw;
  logic [3:0]  bit_idx;
  logic [10:0] rot_bits, sum_bits;
  logic [11:0] rot_shift, adr_shift;
  logic [10:0] rem_rot_nxt, rem_adr_nxt;

  assign sum_raw   = {1'b0, slot_q} + {1'b0, rot_q};
  assign bit_idx   = nrm_cnt_q - 4'd1;
  assign rot_bits  = {1'b0, rot_q} >> bit_idx;
  assign sum_bits  = sum_raw >> bit_idx;
  assign rot_shift = {rem_rot_q, rot_bits[0]};
  assign adr_shift = {rem_adr_q, sum_bits[0]};

  always_comb begin
    rem_rot_nxt = (rot_shift >= {1'b0, count_eff}) ?
                  11'(rot_shift - {1'b0, count_eff}) : rot_shift[10:0];
    rem_adr_nxt = (adr_shift >= {1'b0, count_eff}) ?
                  11'(adr_shift - {1'b0, count_eff}) : adr_shift[10:0];
  end

  always_comb begin
    slot_d    = slot_q;
    phase_d   = phase_q;
    rot_d     = rot_q;
    rot_mod_d = rot_mod_q;
    addr_d    = addr_q;
    nrm_cnt_d = nrm_cnt_q;
    rem_rot_d = rem_rot_q;
    rem_adr_d = rem_adr_q;
    if (pix_req) begin
      if (is_last) begin
        slot_d    = '0;
        phase_d   = '0;
        rot_d     = rot_wrap;
        rot_mod_d = rot_wrap;
        addr_d    = rot_wrap;
      end else begin
        slot_d  = slot_inc[9:0];
        phase_d = phase_q + phase_step_q;
        addr_d  = addr_wrap;
      end
    end
    if (start_nrm) begin
      nrm_cnt_d = tcsf_pkg::NormSteps;
      rem_rot_d = '0;
      rem_adr_d = '0;
    end else if (nrm_busy) begin
      nrm_cnt_d = nrm_cnt_q - 4'd1;
      rem_rot_d = rem_rot_nxt;
      rem_adr_d = rem_adr_nxt;
      if (nrm_cnt_q == 4'd1) begin
        rot_mod_d = rem_rot_nxt[9:0];
        addr_d    = rem_adr_nxt[9:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      phase_q   <= '0;
      rot_q     <= '0;
      rot_mod_q <= '0;
      addr_q    <= '0;
      nrm_cnt_q <= '0;
      rem_rot_q <= '0;
      rem_adr_q <= '0;
    end else begin
      slot_q    <= slot_d;
      phase_q   <= phase_d;
      rot_q     <= rot_d;
      rot_mod_q <= rot_mod_d;
      addr_q    <= addr_d;
      nrm_cnt_q <= nrm_cnt_d;
      rem_rot_q <= rem_rot_d;
      rem_adr_q <= rem_adr_d;
    end
  end

  // First stage: address, frame end and sine weight of the current slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_req) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_req) begin
      s1_addr_q   <= addr_q;
      s1_last_q   <= is_last;
      s1_weight_q <= tcsf_pkg::sine_weight(phase_q);
    end
  end

  // Blend: (c1 * a + c2 * (256 - a)) >> 8 on each channel.
  logic [8:0]  weight_inv;
  logic [16:0] mix_r, mix_g, mix_b;

  assign weight_inv = 9'd256 - {1'b0, s1_weight_q};
  assign mix_r = 17'(first_color_q[23:16]) * 17'(s1_weight_q)
               + 17'(second_color_q[23:16]) * 17'(weight_inv);
  assign mix_g = 17'(first_color_q[15:8]) * 17'(s1_weight_q)
               + 17'(second_color_q[15:8]) * 17'(weight_inv);
  assign mix_b = 17'(first_color_q[7:0]) * 17'(s1_weight_q)
               + 17'(second_color_q[7:0]) * 17'(weight_inv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_addr_q  <= s1_addr_q;
      out_last_q  <= s1_last_q;
      out_red_q   <= mix_r[15:8];
      out_green_q <= mix_g[15:8];
      out_blue_q  <= mix_b[15:8];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_blue_q, out_green_q, out_red_q, out_addr_q};
  assign m_axis_tlast  = out_last_q;

  // No input beat is taken while the remainder pass owns the frame state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrm_busy |-> !s_axis_tready)
    else $error("input accepted during remainder pass");

  // Outside the pass, the reduced address and rotation lie below the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!nrm_busy && !$past(start_nrm)) |->
      ({1'b0, addr_q} < count_eff && {1'b0, rot_mod_q} < count_eff))
    else $error("reduced frame state out of range");

  // The frame end clears slot and phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_req && is_last && !start_nrm) |=> (slot_q == 10'd0 && phase_q == 16'd0))
    else $error("frame end did not clear slot and phase");

  // A pixel waiting in the first stage is never dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("first stage pixel lost");

endmodule

FILE: tb/sv/two_color_sine_fade_cycle_tb.sv
// Self-checking testbench for the two-color sine fade pattern generator.
// A pixel ledger class predicts every pixel from the request stream and the
// register writes; it depends only on tcsf_pkg and two_color_sine_fade_cycle.
`timescale 1ns / 1ps

module two_color_sine_fade_cycle_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 10;

  // round(128 * sin(k * pi / 128)) for k = 0..64.
  localparam int QuarterWave [65] = '{
    0, 3, 6, 9, 13, 16, 19, 22, 25, 28, 31, 34, 37, 40, 43, 46,
    49, 52, 55, 58, 60, 63, 66, 68, 71, 74, 76, 79, 81, 84, 86, 88,
    91, 93, 95, 97, 99, 101, 103, 105, 106, 108, 110, 111, 113, 114, 116, 117,
    118, 119, 121, 122, 122, 123, 124, 125, 126, 126, 127, 127, 127, 128, 128, 128,
    128
  };

  typedef struct packed {
    logic [9:0] addr;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  class pixel_ledger;
    logic [23:0] color_a;
    logic [23:0] color_b;
    logic [10:0] count_reg;
    logic [15:0] step_reg;
    logic [9:0]  slot;
    logic [15:0] phase;
    logic [9:0]  rotation;
    pixel_t      pending_pixels[$];
    int unsigned errors;

    function new();
      color_a   = '0;
      color_b   = '0;
      count_reg = 11'd1024;
      step_reg  = '0;
      slot      = '0;
      phase     = '0;
      rotation  = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        tcsf_pkg::RegFirstColor:  color_a   = value[23:0];
        tcsf_pkg::RegSecondColor: color_b   = value[23:0];
        tcsf_pkg::RegPixelCount:  count_reg = value[10:0];
        tcsf_pkg::RegPhaseStep:   step_reg  = value[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned fade_weight(logic [15:0] ph);
      logic [15:0] quant;
      logic [7:0]  idx;
      int unsigned r;
      int unsigned s;
      int unsigned a;
      quant = (ph >> (16 - tcsf_pkg::SineTableBits)) << (16 - tcsf_pkg::SineTableBits);
      idx   = quant[15:8];
      r     = idx[5:0];
      s     = idx[6] ? QuarterWave[64 - r] : QuarterWave[r];
      a     = idx[7] ? 128 - s : 128 + s;
      return (a > 255) ? 255 : a;
    endfunction

    function logic [7:0] blend_channel(logic [7:0] c1, logic [7:0] c2, int unsigned w);
      int unsigned mix;
      mix = c1 * w + c2 * (256 - w);
      return mix[15:8];
    endfunction

    function void take_request(bit req);
      int unsigned n;
      int unsigned w;
      pixel_t p;
      if (!req) return;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > tcsf_pkg::CountBound) n = tcsf_pkg::CountBound;
      w       = fade_weight(phase);
      p.addr  = 10'((slot + rotation) % n);
      p.red   = blend_channel(color_a[23:16], color_b[23:16], w);
      p.green = blend_channel(color_a[15:8], color_b[15:8], w);
      p.blue  = blend_channel(color_a[7:0], color_b[7:0], w);
      // A slot at or past count-1 closes the frame, which covers a shrunk count.
      p.last  = (slot + 1 >= n);
      pending_pixels.push_back(p);
      if (p.last) begin
        slot     = '0;
        phase    = '0;
        rotation = 10'((rotation + 1) % n);
      end else begin
        slot  = slot + 10'd1;
        phase = phase + step_reg;
      end
    endfunction

    function void compare_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void match_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual addr %0d rgb %h%h%h last %0d",
                 $time, got.addr, got.red, got.green, got.blue, got.last);
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("pixel_address", want.addr, got.addr);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("frame_last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_ledger ledger = new();
  bit          steady = 1'b0;
  int unsigned cycles = 0;

  two_color_sine_fade_cycle DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[two_color_sine_fade_cycle] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 21);
  end

  // Both streams are sampled before this edge's updates land.
  always @(posedge clk_i) begin
    pixel_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) ledger.take_request(s_axis_tdata[0]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.addr  = m_axis_tdata[9:0];
        got.red   = m_axis_tdata[17:10];
        got.green = m_axis_tdata[25:18];
        got.blue  = m_axis_tdata[33:26];
        got.last  = m_axis_tlast;
        ledger.match_pixel(got);
      end
    end
  end

  function automatic bit idle_now();
    return steady ? 1'b0 : ($urandom_range(99) < 21);
  endfunction

  task automatic send_request(input bit req);
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, req};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sends beats until n_req pixel requests have gone in; the rest are no-ops.
  task automatic request_burst(input int n_req, input int noop_pct);
    int sent;
    bit req;
    sent = 0;
    while (sent < n_req) begin
      req = ($urandom_range(99) >= noop_pct);
      send_request(req);
      if (req) sent++;
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (ledger.pending_pixels.size() != 0) @(posedge clk_i);
    // A trailing no-op beat produces no pixel for the ledger to wait on.
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ledger.write_reg(idx, value);
  endtask

  task automatic apb_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [23:0] c1, input logic [23:0] c2,
                             input logic [10:0] count, input logic [15:0] step);
    drain();
    apb_write(tcsf_pkg::RegFirstColor, {8'b0, c1});
    apb_write(tcsf_pkg::RegSecondColor, {8'b0, c2});
    apb_write(tcsf_pkg::RegPixelCount, {21'b0, count});
    apb_write(tcsf_pkg::RegPhaseStep, {16'b0, step});
    apb_idle();
  endtask

  function automatic logic [23:0] pick_color();
    case ($urandom_range(5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [10:0] pick_count();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 11'd0;
          1: return 11'd1;
          2: return 11'd1024;
          default: return 11'd2047;
        endcase
      end
      1: return 11'($urandom_range(2047));
      default: return 11'($urandom_range(40, 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, with a no-op beat in between.
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    s_axis_tvalid <= 1'b0;

    // Quarter-turn steps hit zero, the saturated peak, the midpoint and the trough.
    reconfigure(24'hFFFFFF, 24'h000000, 11'd4, 16'h4000);
    request_burst(5, 0);

    // One-pixel frames with the largest step.
    reconfigure(24'h000000, 24'hFFFFFF, 11'd1, 16'hFFFF);
    request_burst(2, 0);

    // Count of zero acts as one; counts above the bound act as the bound.
    reconfigure(24'hFF00FF, 24'h00FF00, 11'd0, 16'h0001);
    request_burst(1, 0);
    reconfigure(24'h123456, 24'hFEDCBA, 11'd2047, 16'h0100);
    request_burst(2, 0);
    reconfigure(24'h80807F, 24'h7F8080, 11'd1025, 16'h8000);
    request_burst(1, 0);

    // Shrinking the count mid-frame ends the frame at once.
    reconfigure(24'h123456, 24'hABCDEF, 11'd12, 16'h1357);
    request_burst(6, 0);
    drain();
    apb_write(tcsf_pkg::RegPixelCount, 32'd3);
    apb_idle();
    request_burst(2, 0);

    for (int ph = 0; ph < 16; ph++) begin
      reconfigure(pick_color(), pick_color(), pick_count(), pick_step());
      steady = (ph >= 6 && ph <= 8);
      request_burst(62, 8);
      drain();
      steady = 1'b0;
    end

    drain();
    if (ledger.errors == 0) begin
      $display("[two_color_sine_fade_cycle] OK");
    end else begin
      $display("[two_color_sine_fade_cycle] ERROR");
    end
    $finish;
  end

endmodule
